/* rtl/core/nop_pkg.sv */
package nop_pkg;

    typedef enum logic [7:0] {
        PH_START     = 8'b0000_0001,
        PH_SKIP_PRE  = 8'b0000_0010,
        PH_AT        = 8'b0000_0100,
        PH_SKIP_POST = 8'b0000_1000,
        PH_LEAD0     = 8'b0001_0000,
        PH_ZEROS     = 8'b0010_0000,
        PH_DIGITS    = 8'b0100_0000,
        PH_DONE      = 8'b1000_0000
    } phase_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_SYNTAX  = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ADDR  = 2'd1;
    localparam logic [1:0] MODE_IMM   = 2'd2;
    localparam logic [1:0] MODE_RSVD  = 2'd3;

    localparam logic [1:0] HALF_NONE = 2'd0;
    localparam logic [1:0] HALF_HIGH = 2'd1;
    localparam logic [1:0] HALF_LOW  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_UP_L  = 8'h4c;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CASE_FOLD_MASK = 8'hdf;
    localparam logic [7:0] LOWER_BIT      = 8'h20;

    localparam logic [31:0] SHORT_LIMIT = 32'h0000_ffff;
    localparam logic [31:0] BYTE_MASK   = 32'h0000_00ff;

endpackage

/* rtl/core/numeric_operand_parser.sv */
// A character transaction is taken into the input register and decoded from there;
// the result of a last character is registered and offered on the master side.
// Throughput: one character per cycle, set by the single decode step between the
// input register and the result register; a stalled result holds only last characters.
// Reset: rst_n is asynchronous and active low; it empties both registers and returns
// the parser to waiting for the first character of an operand.
module numeric_operand_parser
    import nop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic [1:0]  in_mode_reg;
    logic        in_last_reg;
    logic        advance;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic        ovf_reg, ovf_next;
    logic        hex_reg, hex_next;
    logic [1:0]  half_reg, half_next;
    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  err_reg, err_next;

    logic        out_valid_reg;
    logic [31:0] out_value_reg, out_value_next;
    logic [1:0]  out_status_reg, out_status_next;

    logic        is_blank;
    logic        dig_ok;
    logic [3:0]  dig_val;
    logic [7:0]  folded;
    logic [35:0] scaled;
    logic [35:0] run_sum;
    logic        do_lead;
    logic        do_run;
    logic [31:0] sel_value;

    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_ch_reg   <= s_axis_tdata;
            in_mode_reg <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
    end

    assign is_blank = (in_ch_reg == CH_SPACE)
                   || (in_ch_reg >= CH_TAB && in_ch_reg <= CH_CR && in_ch_reg != CH_LF);
    assign folded = in_ch_reg & CASE_FOLD_MASK;

    always_comb
    begin
        dig_ok  = 1'b0;
        dig_val = 4'd0;
        if (in_ch_reg >= CH_ZERO && in_ch_reg <= CH_NINE)
        begin
            dig_ok  = 1'b1;
            dig_val = 4'(in_ch_reg - CH_ZERO);
        end
        else if (hex_reg && ((in_ch_reg | LOWER_BIT) >= CH_LO_A)
                 && ((in_ch_reg | LOWER_BIT) <= CH_LO_F))
        begin
            dig_ok  = 1'b1;
            dig_val = 4'((in_ch_reg | LOWER_BIT) - CH_LO_A + 8'd10);
        end
    end

    assign scaled  = hex_reg ? {acc_reg, 4'b0000}
                             : ({1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0});
    assign run_sum = scaled + {32'd0, dig_val};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        hex_next   = hex_reg;
        half_next  = half_reg;
        mode_next  = mode_reg;
        err_next   = err_reg;
        do_lead    = 1'b0;
        do_run     = 1'b0;
        out_value_next  = 32'd0;
        out_status_next = ST_OK;
        sel_value       = acc_reg;

        if (phase_next == PH_START)
        begin
            mode_next  = (in_mode_reg == MODE_RSVD) ? MODE_PLAIN : in_mode_reg;
            phase_next = PH_SKIP_PRE;
        end

        if (in_ch_reg == CH_NUL)
        begin
            if (phase_next == PH_SKIP_PRE || phase_next == PH_SKIP_POST)
            begin
                err_next = ST_MISSING;
            end
            else if (phase_next == PH_AT)
            begin
                err_next = ST_SYNTAX;
            end
            phase_next = PH_DONE;
        end
        else
        begin
            unique case (phase_next)
                PH_SKIP_PRE:
                begin
                    if (!is_blank)
                    begin
                        if (in_ch_reg == CH_AT && mode_next != MODE_PLAIN)
                        begin
                            phase_next = PH_AT;
                        end
                        else
                        begin
                            do_lead = 1'b1;
                        end
                    end
                end
                PH_AT:
                begin
                    if (!in_ch_reg[7] && (folded == CH_UP_H || folded == CH_UP_L))
                    begin
                        if (mode_next == MODE_IMM)
                        begin
                            half_next = (folded == CH_UP_H) ? HALF_HIGH : HALF_LOW;
                        end
                        phase_next = PH_SKIP_POST;
                    end
                    else
                    begin
                        err_next   = ST_SYNTAX;
                        phase_next = PH_DONE;
                    end
                end
                PH_SKIP_POST:
                begin
                    do_lead = !is_blank;
                end
                PH_LEAD0:
                begin
                    if (in_ch_reg == CH_LO_X || in_ch_reg == CH_UP_X)
                    begin
                        hex_next   = 1'b1;
                        phase_next = PH_ZEROS;
                    end
                    else if (in_ch_reg == CH_ZERO)
                    begin
                        phase_next = PH_ZEROS;
                    end
                    else
                    begin
                        do_run = 1'b1;
                    end
                end
                PH_ZEROS:
                begin
                    do_run = (in_ch_reg != CH_ZERO);
                end
                PH_DIGITS:
                begin
                    do_run = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (do_lead)
        begin
            if (in_ch_reg == CH_ZERO || in_ch_reg == CH_DOLLAR)
            begin
                hex_next   = (in_ch_reg == CH_DOLLAR);
                phase_next = PH_LEAD0;
            end
            else if (in_ch_reg >= CH_ONE && in_ch_reg <= CH_NINE)
            begin
                hex_next   = 1'b0;
                acc_next   = {24'd0, in_ch_reg - CH_ZERO};
                phase_next = PH_DIGITS;
            end
            else
            begin
                err_next   = (in_ch_reg == CH_LF) ? ST_MISSING : ST_SYNTAX;
                phase_next = PH_DONE;
            end
        end

        if (do_run)
        begin
            if (dig_ok)
            begin
                if (run_sum[35:32] != 4'd0)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = run_sum[31:0];
                end
                phase_next = PH_DIGITS;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        if (in_last_reg)
        begin
            if (phase_next == PH_SKIP_PRE || phase_next == PH_SKIP_POST)
            begin
                err_next = ST_MISSING;
            end
            else if (phase_next == PH_AT)
            begin
                err_next = ST_SYNTAX;
            end

            out_status_next = err_next;
            if (err_next == ST_OK)
            begin
                if (ovf_next || (mode_next != MODE_PLAIN && acc_next > SHORT_LIMIT))
                begin
                    out_status_next = ST_RANGE;
                end
                else
                begin
                    sel_value = acc_next;
                    if (half_next == HALF_HIGH)
                    begin
                        sel_value = acc_next >> 8;
                    end
                    else if (half_next == HALF_LOW)
                    begin
                        sel_value = acc_next & BYTE_MASK;
                    end
                    out_value_next = sel_value;
                end
            end

            phase_next = PH_START;
            acc_next   = 32'd0;
            ovf_next   = 1'b0;
            hex_next   = 1'b0;
            half_next  = HALF_NONE;
            mode_next  = MODE_PLAIN;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            acc_reg   <= 32'd0;
            ovf_reg   <= 1'b0;
            hex_reg   <= 1'b0;
            half_reg  <= HALF_NONE;
            mode_reg  <= MODE_PLAIN;
            err_reg   <= ST_OK;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            ovf_reg   <= ovf_next;
            hex_reg   <= hex_next;
            half_reg  <= half_next;
            mode_reg  <= mode_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    // A result that is not ok carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 32'd0))
        else $error("non-ok result with nonzero value");

    // The last character of an operand leaves the parser cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (phase_reg == PH_START && acc_reg == 32'd0
                                      && err_reg == ST_OK && !ovf_reg))
        else $error("parser not cleared after last character");

    // A held character stays in the input register until it is decoded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_ch_reg)
                                        && $stable(in_last_reg)))
        else $error("held character lost or changed");

    // Overflow can only be seen once a digit run has started.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (phase_reg == PH_DIGITS || phase_reg == PH_DONE))
        else $error("overflow flagged outside a digit run");

    // A stalled result blocks only a last character behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_last_reg) |-> advance)
        else $error("non-final character stalled");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
    import nop_pkg::*;

    localparam int unsigned ITEM_TARGET = 550;
    localparam int unsigned DIRECTED_COUNT = 24;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] mode;
        logic       fin;
        logic       typed;
        result_t    known;
    } row_t;

    localparam row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{"0",       MODE_PLAIN, 1'b1, 1'b1, '{32'h0,  ST_OK}},
        '{CH_LF,     MODE_ADDR,  1'b1, 1'b1, '{32'h0,  ST_MISSING}},
        '{CH_AT,     MODE_IMM,   1'b1, 1'b1, '{32'h0,  ST_SYNTAX}},
        '{CH_AT,     MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"h",       MODE_PLAIN, 1'b1, 1'b1, '{32'h0,  ST_MISSING}},
        '{CH_AT,     MODE_PLAIN, 1'b1, 1'b1, '{32'h0,  ST_SYNTAX}},
        '{CH_DOLLAR, MODE_RSVD,  1'b1, 1'b1, '{32'h0,  ST_OK}},
        '{CH_NUL,    MODE_ADDR,  1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"7",       MODE_ADDR,  1'b1, 1'b1, '{32'h0,  ST_MISSING}},
        '{8'hff,     MODE_IMM,   1'b1, 1'b1, '{32'h0,  ST_SYNTAX}},
        '{CH_DOLLAR, MODE_ADDR,  1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"1",       MODE_ADDR,  1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"0",       MODE_ADDR,  1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"0",       MODE_ADDR,  1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"0",       MODE_ADDR,  1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"0",       MODE_ADDR,  1'b1, 1'b1, '{32'h0,  ST_RANGE}},
        '{CH_AT,     MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"H",       MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{CH_TAB,    MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{CH_DOLLAR, MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"a",       MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"B",       MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"c",       MODE_IMM,   1'b0, 1'b0, '{32'h0,  ST_OK}},
        '{"d",       MODE_IMM,   1'b1, 1'b1, '{32'hab, ST_OK}}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic [1:0]  s_axis_tuser = MODE_PLAIN;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    result_t     pending_results[$];
    logic [7:0]  operand_text[$];
    logic [1:0]  operand_mode;
    bit          send_calm;
    bit          take_calm;
    int unsigned chars_sent;
    int unsigned operands_sent;
    int unsigned results_seen;
    int unsigned error_count;

    phase_t      parse_phase;
    logic [31:0] accum;
    bit          overflowed;
    bit          hex_number;
    logic [1:0]  half_sel;
    logic [1:0]  latched_mode;
    logic [1:0]  parse_error;

    numeric_operand_parser DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic int unsigned draw_gap(inout bit calm);
        if ($urandom_range(0, 19) == 0)
        begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR && c != CH_LF);
    endfunction

    function void clear_parser();
        parse_phase  = PH_START;
        accum        = 32'h0;
        overflowed   = 1'b0;
        hex_number   = 1'b0;
        half_sel     = HALF_NONE;
        latched_mode = MODE_PLAIN;
        parse_error  = ST_OK;
    endfunction

    function void scan_digit(logic [7:0] c);
        logic [7:0]  low;
        logic [3:0]  d;
        bit          ok;
        logic [63:0] nxt;
        low = c | LOWER_BIT;
        ok = 1'b0;
        d = 4'd0;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            ok = 1'b1;
            d = 4'(c - CH_ZERO);
        end
        else if (hex_number && low >= CH_LO_A && low <= CH_LO_F)
        begin
            ok = 1'b1;
            d = 4'(low - CH_LO_A + 8'd10);
        end
        if (ok)
        begin
            nxt = {32'd0, accum} * (hex_number ? 64'd16 : 64'd10) + {60'd0, d};
            if (nxt > 64'hffff_ffff)
            begin
                overflowed = 1'b1;
            end
            else
            begin
                accum = nxt[31:0];
            end
            parse_phase = PH_DIGITS;
        end
        else
        begin
            parse_phase = PH_DONE;
        end
    endfunction

    function void take_lead(logic [7:0] c);
        if (c == CH_ZERO || c == CH_DOLLAR)
        begin
            hex_number = (c == CH_DOLLAR);
            parse_phase = PH_LEAD0;
        end
        else if (c >= CH_ONE && c <= CH_NINE)
        begin
            hex_number = 1'b0;
            accum = 32'(c - CH_ZERO);
            parse_phase = PH_DIGITS;
        end
        else
        begin
            parse_error = (c == CH_LF) ? ST_MISSING : ST_SYNTAX;
            parse_phase = PH_DONE;
        end
    endfunction

    function void close_text();
        if (parse_phase == PH_START || parse_phase == PH_SKIP_PRE
            || parse_phase == PH_SKIP_POST)
        begin
            parse_error = ST_MISSING;
        end
        else if (parse_phase == PH_AT)
        begin
            parse_error = ST_SYNTAX;
        end
        parse_phase = PH_DONE;
    endfunction

    function void parse_char(input logic [7:0] c, input logic [1:0] m, input logic fin,
                             output bit has_result, output result_t res);
        logic [7:0] u;
        has_result = 1'b0;
        res = '{32'h0, ST_OK};
        if (parse_phase == PH_START)
        begin
            latched_mode = (m == MODE_RSVD) ? MODE_PLAIN : m;
            parse_phase = PH_SKIP_PRE;
        end
        if (c == CH_NUL)
        begin
            close_text();
        end
        else
        begin
            case (parse_phase)
                PH_SKIP_PRE:
                begin
                    if (!is_blank(c))
                    begin
                        if (c == CH_AT && latched_mode != MODE_PLAIN)
                        begin
                            parse_phase = PH_AT;
                        end
                        else
                        begin
                            take_lead(c);
                        end
                    end
                end
                PH_AT:
                begin
                    u = c & CASE_FOLD_MASK;
                    if (c < 8'h80 && (u == CH_UP_H || u == CH_UP_L))
                    begin
                        if (latched_mode == MODE_IMM)
                        begin
                            half_sel = (u == CH_UP_H) ? HALF_HIGH : HALF_LOW;
                        end
                        parse_phase = PH_SKIP_POST;
                    end
                    else
                    begin
                        parse_error = ST_SYNTAX;
                        parse_phase = PH_DONE;
                    end
                end
                PH_SKIP_POST:
                begin
                    if (!is_blank(c))
                    begin
                        take_lead(c);
                    end
                end
                PH_LEAD0:
                begin
                    if (c == CH_LO_X || c == CH_UP_X)
                    begin
                        hex_number = 1'b1;
                        parse_phase = PH_ZEROS;
                    end
                    else if (c == CH_ZERO)
                    begin
                        parse_phase = PH_ZEROS;
                    end
                    else
                    begin
                        scan_digit(c);
                    end
                end
                PH_ZEROS:
                begin
                    if (c != CH_ZERO)
                    begin
                        scan_digit(c);
                    end
                end
                PH_DIGITS:
                begin
                    scan_digit(c);
                end
                default:
                begin
                end
            endcase
        end
        if (fin)
        begin
            close_text();
            has_result = 1'b1;
            res.status = parse_error;
            if (parse_error == ST_OK)
            begin
                if (overflowed || (latched_mode != MODE_PLAIN && accum > SHORT_LIMIT))
                begin
                    res.status = ST_RANGE;
                end
                else if (half_sel == HALF_HIGH)
                begin
                    res.value = accum >> 8;
                end
                else if (half_sel == HALF_LOW)
                begin
                    res.value = accum & BYTE_MASK;
                end
                else
                begin
                    res.value = accum;
                end
            end
            clear_parser();
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input logic [1:0] m, input logic fin,
                             input bit typed, input result_t known);
        int unsigned gap;
        bit          has_result;
        result_t     res;
        gap = draw_gap(send_calm);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= c;
        s_axis_tuser  <= m;
        s_axis_tlast  <= fin;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        chars_sent++;
        parse_char(c, m, fin, has_result, res);
        if (has_result)
        begin
            pending_results.push_back(typed ? known : res);
        end
    endtask

    function automatic logic [7:0] pick_blank();
        logic [7:0] c;
        c = 8'($urandom_range(CH_TAB, CH_CR));
        if (c == CH_LF || $urandom_range(0, 1) == 1)
        begin
            c = CH_SPACE;
        end
        return c;
    endfunction

    task automatic make_operand();
        string      digits;
        logic [31:0] num;
        logic [7:0]  c;
        operand_text.delete();
        operand_mode = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 12)
        begin
            repeat ($urandom_range(1, 6)) operand_text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) operand_text.push_back(pick_blank());
        if ($urandom_range(0, 99) < 35
            && (operand_mode != MODE_PLAIN || $urandom_range(0, 9) == 0))
        begin
            operand_text.push_back(CH_AT);
            if ($urandom_range(0, 9) == 0)
            begin
                operand_text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                c = $urandom_range(0, 1) ? CH_UP_H : CH_UP_L;
                operand_text.push_back(c | ($urandom_range(0, 1) ? LOWER_BIT : 8'h00));
            end
            repeat ($urandom_range(0, 2)) operand_text.push_back(pick_blank());
        end
        num = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1)
        begin
            case ($urandom_range(0, 2))
                0: operand_text.push_back(CH_DOLLAR);
                1: operand_text.push_back(CH_ZERO);
                default: operand_text.push_back(CH_ZERO);
            endcase
            if (operand_text[$] == CH_ZERO)
            begin
                operand_text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
            end
            digits = $sformatf("%0h", num);
        end
        else
        begin
            digits = $sformatf("%0d", num);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) operand_text.push_back(CH_ZERO);
        end
        for (int k = 0; k < digits.len(); k++)
        begin
            c = digits[k];
            if (c >= CH_LO_A && $urandom_range(0, 1) == 1)
            begin
                c = c & CASE_FOLD_MASK;
            end
            operand_text.push_back(c);
        end
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 3))
                operand_text.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) operand_text.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            operand_text[$urandom_range(0, operand_text.size() - 1)] =
                8'($urandom_range(0, 255));
        end
    endtask

    initial
    begin
        int unsigned w;
        result_t     want;
        wait (rst_n === 1'b1);
        forever
        begin
            w = draw_gap(take_calm);
            if (w != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $error("unexpected result transaction: value %h, status %0d",
                       m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata !== want.value)
                begin
                    error_count++;
                    $error("value: expected %h, actual %h", want.value, m_axis_tdata);
                end
                if (m_axis_tuser !== want.status)
                begin
                    error_count++;
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                end
            end
        end
    end

    initial
    begin
        bit paused;
        clear_parser();
        paused = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            send_char(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].fin,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].known);
            if (DIRECTED_ROWS[i].fin)
            begin
                operands_sent++;
            end
        end
        while (chars_sent < ITEM_TARGET)
        begin
            if (!paused && chars_sent >= ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end
            make_operand();
            foreach (operand_text[k])
            begin
                send_char(operand_text[k], (k == 0) ? operand_mode : 2'($urandom_range(0, 3)),
                          k == operand_text.size() - 1, 1'b0, '{32'h0, ST_OK});
            end
            operands_sent++;
        end
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (4) @(posedge clk);
        $display("Sent %0d characters in %0d operands across all modes and prefixes;",
                 chars_sent, operands_sent);
        $display("checked %0d result transactions, %0d mismatches.",
                 results_seen, error_count);
        if (error_count == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/nop_pkg.sv
rtl/core/numeric_operand_parser.sv
tb/sv/tb.sv
